@@ design/vdu_pkg.sv @@
package vdu_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int ELEMENT_WIDTH = 16;
    localparam int SUM_W         = 48;
    localparam int PROD_W        = 2 * ELEMENT_WIDTH + 3;
    localparam int CNT_W         = $clog2(MAX_DIM + 1);
    localparam int QDEPTH        = 2;
    localparam int QCNT_W        = $clog2(QDEPTH + 1);
    localparam int COS_W         = 18;
    localparam int ONE_Q16       = 65536;

    typedef enum logic [1:0]
    {
        METRIC_L2   = 2'd0,
        METRIC_COS  = 2'd1,
        METRIC_IP   = 2'd2,
        METRIC_NONE = 2'd3
    } metric_t;

    typedef struct packed
    {
        metric_t                   metric;
        logic signed [SUM_W-1:0]   main_sum;
        logic signed [SUM_W-1:0]   norm_a;
        logic signed [SUM_W-1:0]   norm_b;
    } sums_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [PROD_W-1:0] x
    );
        logic signed [SUM_W:0] r;
        logic signed [SUM_W-1:0] o;
        r = {s[SUM_W-1], s} + {{(SUM_W + 1 - PROD_W){x[PROD_W-1]}}, x};
        if (r[SUM_W] != r[SUM_W-1])
        begin
            o = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            o = r[SUM_W-1:0];
        end
        return o;
    endfunction

endpackage

@@ design/vdu_front.sv @@
module vdu_front
    import vdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              s_tlast,
    input  logic              metric_we,
    input  logic [1:0]        metric_wdata,
    input  logic [QCNT_W-1:0] q_count,
    output logic              push,
    output sums_t             push_data
);

    metric_t                  metric_reg;
    logic                     p_valid_reg;
    logic                     p_last_reg;
    metric_t                  p_metric_reg;
    logic signed [PROD_W-1:0] p_main_reg;
    logic signed [PROD_W-1:0] p_aa_reg;
    logic signed [PROD_W-1:0] p_bb_reg;
    logic signed [SUM_W-1:0]  main_reg, na_reg, nb_reg;
    logic signed [SUM_W-1:0]  main_next, na_next, nb_next;
    logic [CNT_W-1:0]         cnt_reg;

    logic [ELEMENT_WIDTH-1:0] ea, eb;
    logic signed [PROD_W-1:0] ax, bx, dx;
    logic                     accept;

    assign ea = s_tdata[ELEMENT_WIDTH-1:0];
    assign eb = s_tdata[16 + ELEMENT_WIDTH - 1:16];
    assign ax = {{(PROD_W - ELEMENT_WIDTH){ea[ELEMENT_WIDTH-1]}}, ea};
    assign bx = {{(PROD_W - ELEMENT_WIDTH){eb[ELEMENT_WIDTH-1]}}, eb};
    assign dx = ax - bx;

    // an in-flight last item holds a queue slot
    assign s_tready = (QCNT_W'(q_count + QCNT_W'(p_valid_reg & p_last_reg)))
                      < QCNT_W'(QDEPTH);
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        main_next = main_reg;
        na_next   = na_reg;
        nb_next   = nb_reg;
        if (cnt_reg < CNT_W'(MAX_DIM))
        begin
            main_next = sat_add(main_reg, p_main_reg);
            na_next   = sat_add(na_reg, p_aa_reg);
            nb_next   = sat_add(nb_reg, p_bb_reg);
        end
    end

    assign push               = p_valid_reg & p_last_reg;
    assign push_data.metric   = p_metric_reg;
    assign push_data.main_sum = main_next;
    assign push_data.norm_a   = na_next;
    assign push_data.norm_b   = nb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg  <= METRIC_L2;
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            main_reg    <= '0;
            na_reg      <= '0;
            nb_reg      <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (metric_we)
            begin
                metric_reg <= metric_t'(metric_wdata);
            end
            p_valid_reg <= accept;
            if (accept)
            begin
                p_last_reg <= s_tlast;
            end
            if (p_valid_reg)
            begin
                if (p_last_reg)
                begin
                    main_reg <= '0;
                    na_reg   <= '0;
                    nb_reg   <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    main_reg <= main_next;
                    na_reg   <= na_next;
                    nb_reg   <= nb_next;
                    if (cnt_reg < CNT_W'(MAX_DIM))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_metric_reg <= metric_reg;
            p_main_reg   <= (metric_reg == METRIC_L2) ? dx * dx : ax * bx;
            p_aa_reg     <= ax * ax;
            p_bb_reg     <= bx * bx;
        end
    end

endmodule

@@ design/vdu_queue.sv @@
module vdu_queue
    import vdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sums_t             push_data,
    input  logic              pop,
    output sums_t             head,
    output logic              not_empty,
    output logic [QCNT_W-1:0] count
);

    localparam int PTR_W = $clog2(QDEPTH);

    sums_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign head      = mem_reg[rd_reg];
    assign not_empty = cnt_reg != '0;
    assign count     = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

@@ design/vdu_back.sv @@
module vdu_back
    import vdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sums_t       head,
    input  logic        not_empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    metric_t                 metric_reg;
    logic signed [SUM_W-1:0] dot_reg, na_reg, nb_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic [2:0]              step_reg;
    logic [95:0]             sq_reg, pr_reg;
    logic [129:0]            rem_reg;
    logic [130:0]            dvs_reg;
    logic [35:0]             q_reg;
    logic [5:0]              dcnt_reg;
    logic [34:0]             num_reg, res_reg, bit_reg;
    logic [47:0]             result_reg;
    logic                    out_valid_reg;
    logic [47:0]             out_reg;

    logic [23:0]  xh, yh;
    logic [47:0]  pp;
    logic [95:0]  pp_sh;
    logic [SUM_W-1:0] xo, yo;
    logic         qbit;
    logic [35:0]  q_next;
    logic [34:0]  trial;
    logic         take;
    logic [17:0]  kk, kc;
    logic [COS_W-1:0] cos_q;
    logic         out_load;

    assign pop      = (state_reg == ST_IDLE) && not_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // 24x24 partial products, four per 48x48 product
    assign xo    = step_reg[2] ? na_reg : mag_reg;
    assign yo    = step_reg[2] ? nb_reg : mag_reg;
    assign xh    = step_reg[0] ? xo[47:24] : xo[23:0];
    assign yh    = step_reg[1] ? yo[47:24] : yo[23:0];
    assign pp    = xh * yh;
    assign pp_sh = ({48'b0, pp} << (7'd24 * (7'(step_reg[0]) + 7'(step_reg[1]))));

    assign qbit   = {1'b0, rem_reg} >= dvs_reg;
    assign q_next = {q_reg[34:0], qbit};

    assign trial = res_reg + bit_reg;
    assign take  = num_reg >= trial;

    assign kk    = 18'(({1'b0, res_reg[17:0]} + 19'd1) >> 1);
    assign kc    = (kk > 18'(ONE_Q16)) ? 18'(ONE_Q16) : kk;
    assign cos_q = dot_reg[SUM_W-1] ? COS_W'(ONE_Q16) + kc : COS_W'(ONE_Q16) - kc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (not_empty)
                    begin
                        metric_reg <= head.metric;
                        dot_reg    <= head.main_sum;
                        na_reg     <= head.norm_a;
                        nb_reg     <= head.norm_b;
                        mag_reg    <= head.main_sum[SUM_W-1] ? -head.main_sum
                                                             : head.main_sum;
                        state_reg  <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    case (metric_reg)
                        METRIC_L2:   result_reg <= dot_reg;
                        METRIC_IP:   result_reg <= -dot_reg;
                        METRIC_COS:  result_reg <= 48'(ONE_Q16);
                        default:     result_reg <= '0;
                    endcase
                    if (metric_reg == METRIC_COS && !na_reg[SUM_W-1] && na_reg != '0
                        && !nb_reg[SUM_W-1] && nb_reg != '0)
                    begin
                        step_reg  <= '0;
                        sq_reg    <= '0;
                        pr_reg    <= '0;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_MUL:
                begin
                    if (step_reg[2])
                    begin
                        pr_reg <= pr_reg + pp_sh;
                    end
                    else
                    begin
                        sq_reg <= sq_reg + pp_sh;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd7)
                    begin
                        rem_reg   <= {sq_reg, 34'b0};
                        dvs_reg   <= {pr_reg + pp_sh, 35'b0};
                        q_reg     <= '0;
                        dcnt_reg  <= 6'd35;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (qbit)
                    begin
                        rem_reg <= rem_reg - dvs_reg[129:0];
                    end
                    dvs_reg  <= dvs_reg >> 1;
                    q_reg    <= q_next;
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == '0)
                    begin
                        if (q_next[35])
                        begin
                            // quotient too large: cosine clamps at full scale
                            result_reg <= 48'(dot_reg[SUM_W-1] ? 2 * ONE_Q16 : 0);
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            num_reg   <= q_next[34:0];
                            res_reg   <= '0;
                            bit_reg   <= 35'd1 << 34;
                            state_reg <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        result_reg <= 48'(cos_q);
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        if (take)
                        begin
                            num_reg <= num_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_reg   <= result_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/vector_distance_unit.sv @@
// Channel  Dir  Handshake            Payload
// s        in   s_tvalid/s_tready    s_tdata: elem_a, elem_b; s_tlast: last_element
// m        out  m_tvalid/m_tready    m_tdata: distance
// cfg      in   metric_we            metric_wdata: metric
//
// Element pairs are taken one per cycle while the two-entry queue is not full,
// counting a finished sum still in flight; input stalls only when it is full.
// Each pair's products are registered, then added to the sums. Cosine takes 8
// partial products, 36 divide steps and 18 square-root steps in one shared unit.
// rst_n clears all sums, the metric and the queue.
module vector_distance_unit
    import vdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // elem_a [15:0], elem_b [31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // distance [47:0]
    input  logic        metric_we,
    input  logic [1:0]  metric_wdata
);

    logic              push, pop, not_empty;
    sums_t             push_data, head;
    logic [QCNT_W-1:0] q_count;

    vdu_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .metric_we    (metric_we),
        .metric_wdata (metric_wdata),
        .q_count      (q_count),
        .push         (push),
        .push_data    (push_data)
    );

    vdu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (q_count)
    );

    vdu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ design/vdu_checker.sv @@
module vdu_checker
    import vdu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        metric_we,
    input logic [1:0]  metric_wdata
);

    metric_t    metric_reg;
    logic [2:0] pend_reg;
    logic       in_last, out_take;

    assign in_last  = s_tvalid & s_tready & s_tlast;
    assign out_take = m_tvalid & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_L2;
            pend_reg   <= '0;
        end
        else
        begin
            if (metric_we)
            begin
                metric_reg <= metric_t'(metric_wdata);
            end
            pend_reg <= pend_reg + 3'(in_last) - 3'(out_take);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != '0)
        else $error("result without a last item");

    a_cos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && metric_reg == METRIC_COS |->
            m_tdata[47:18] == '0 && m_tdata[17:0] <= 18'(2 * ONE_Q16))
        else $error("cosine out of range");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && metric_reg == METRIC_NONE |-> m_tdata == '0)
        else $error("unused metric gave nonzero");

endmodule

bind vector_distance_unit vdu_checker u_vdu_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .metric_we    (metric_we),
    .metric_wdata (metric_wdata)
);

@@ dv/vector_distance_unit_tb.sv @@
`timescale 1ns / 100ps

module vector_distance_unit_tb
    import vdu_pkg::*;
();

    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 100000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // elem_a [15:0], elem_b [31:16]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // distance [47:0]
    logic        metric_we;
    logic [1:0]  metric_wdata;

    metric_t          cur_metric;
    logic signed [47:0] acc_main;
    logic signed [47:0] acc_na;
    logic signed [47:0] acc_nb;
    int unsigned      acc_count;

    logic [47:0] distance_q[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          idle_cycles;
    bit          long_hold;
    bit          stall_mode;

    vector_distance_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .metric_we    (metric_we),
        .metric_wdata (metric_wdata)
    );

    always #2 clk = ~clk;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF_FFFF)
        begin
            return 48'sh7FFF_FFFF_FFFF;
        end
        if (v < -64'sh8000_0000_0000)
        begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

    // round-to-nearest cosine in Q2.16, exact integer search
    function automatic logic [47:0] cosine_q16(input logic signed [47:0] dot,
                                               input logic signed [47:0] na,
                                               input logic signed [47:0] nb);
        logic [255:0] lhs;
        logic [255:0] prod;
        logic [255:0] odd;
        logic [47:0]  mag;
        longint       lo;
        longint       hi;
        longint       mid;
        if (na <= 0 || nb <= 0)
        begin
            return 48'(ONE_Q16);
        end
        mag = dot < 0 ? -dot : dot;
        lhs = (256'(mag) * 256'(mag)) << 34;
        prod = 256'(na) * 256'(nb);
        lo = 0;
        hi = ONE_Q16;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >>> 1;
            odd = 256'(2 * mid - 1);
            if (prod * odd * odd <= lhs)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return dot < 0 ? 48'(ONE_Q16 + lo) : 48'(ONE_Q16 - lo);
    endfunction

    task automatic predict_distance(input logic [15:0] ea, input logic [15:0] eb,
                                    input logic last);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [47:0]        exp_dist;
        a = 64'(signed'(ea));
        b = 64'(signed'(eb));
        if (acc_count < MAX_DIM)
        begin
            acc_main = sat48(64'(acc_main) + (cur_metric == METRIC_L2 ? (a - b) * (a - b) : a * b));
            acc_na = sat48(64'(acc_na) + a * a);
            acc_nb = sat48(64'(acc_nb) + b * b);
            acc_count++;
        end
        if (last)
        begin
            case (cur_metric)
                METRIC_L2:  exp_dist = acc_main;
                METRIC_COS: exp_dist = cosine_q16(acc_main, acc_na, acc_nb);
                METRIC_IP:  exp_dist = -acc_main;
                default:    exp_dist = '0;
            endcase
            distance_q.push_back(exp_dist);
            acc_main = '0;
            acc_na = '0;
            acc_nb = '0;
            acc_count = 0;
        end
    endtask

    task automatic random_gap(output int n);
        int r;
        r = $urandom_range(0, 99);
        if (stall_mode == 0 || r < 55)
        begin
            n = 0;
        end
        else if (r < 95)
        begin
            n = $urandom_range(1, 3);
        end
        else
        begin
            n = $urandom_range(10, 40);
        end
    endtask

    task automatic send_item(input logic [15:0] ea, input logic [15:0] eb, input logic last);
        int gap;
        random_gap(gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {eb, ea};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_distance(ea, eb, last);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (distance_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_metric(input metric_t m);
        wait_drained();
        metric_we <= 1'b1;
        metric_wdata <= m;
        @(posedge clk);
        metric_we <= 1'b0;
        cur_metric = m;
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_item(rand_elem(), rand_elem(), i == len - 1);
        end
    endtask

    task automatic test_directed();
        metric_t m;
        m = METRIC_L2;
        for (int k = 0; k < 4; k++)
        begin
            write_metric(m);
            send_item(16'h8000, 16'h7FFF, 1'b0);
            send_item(16'h7FFF, 16'h8000, 1'b1);
            send_item(16'h0000, 16'h1234, 1'b1);
            send_item(16'h0003, 16'h0003, 1'b0);
            send_item(16'hFFFD, 16'hFFFD, 1'b1);
            send_item(16'h0001, 16'hFFFF, 1'b1);
            m = metric_t'(m + 1);
        end
    endtask

    task automatic test_metric_switch();
        write_metric(METRIC_COS);
        send_item(16'h0100, 16'h0200, 1'b0);
        write_metric(METRIC_L2);
        send_item(16'h0300, 16'hFF00, 1'b0);
        send_item(16'h0010, 16'h0020, 1'b1);
    endtask

    task automatic test_random();
        metric_t m;
        stall_mode = 1;
        while (items_sent < 1250)
        begin
            m = metric_t'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
            begin
                write_metric(m);
            end
            for (int v = 0; v < 8; v++)
            begin
                send_vector($urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(16'($urandom), 16'($urandom), 1'b0);
            end
        end
    endtask

    task automatic test_backpressure();
        write_metric(METRIC_COS);
        stall_mode = 0;
        long_hold = 1;
        for (int v = 0; v < 6; v++)
        begin
            send_vector(2);
        end
        wait_drained();
        stall_mode = 1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (long_hold)
        begin
            m_tready <= 1'b0;
            repeat (300) @(posedge clk);
            long_hold <= 1'b0;
        end
        else
        begin
            m_tready <= !stall_mode || $urandom_range(0, 99) < 70
                        || ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b1) && $urandom_range(0, 1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (distance_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected distance %h", m_tdata);
                end
            end
            else if (m_tdata !== distance_q[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("distance exp %h act %h", distance_q[0], m_tdata);
                end
                void'(distance_q.pop_front());
            end
            else
            begin
                void'(distance_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n || long_hold)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("vector_distance_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        metric_we = 0;
        metric_wdata = METRIC_L2;
        cur_metric = METRIC_L2;
        acc_main = '0;
        acc_na = '0;
        acc_nb = '0;
        acc_count = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        long_hold = 0;
        stall_mode = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_metric_switch();
        test_backpressure();
        test_random();
        wait_drained();
        $display("ran %0d items, checked %0d distances over all metrics,", items_sent,
                 results_seen);
        $display("including a metric switch mid-vector and long output stalls");
        if (mismatches == 0 && distance_q.size() == 0)
        begin
            $display("vector_distance_unit: match");
        end
        else
        begin
            $display("vector_distance_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/vdu_pkg.sv
design/vdu_front.sv
design/vdu_queue.sv
design/vdu_back.sv
design/vector_distance_unit.sv
design/vdu_checker.sv
dv/vector_distance_unit_tb.sv
